// ===== rtl/tpi_pkg.sv =====
// shared types, widths and index tables for the three-plane intersection block
// no dependencies; every other file imports this package
`default_nettype none

package tpi_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    localparam int PROD_W  = 2 * WORD_BITS;
    localparam int MINOR_W = 2 * WORD_BITS + 1;
    localparam int HI_W    = MINOR_W - WORD_BITS;
    localparam int PP_W    = WORD_BITS + HI_W;
    localparam int SUM_W   = 3 * WORD_BITS + 2;
    localparam int QB      = WORD_BITS - 1;
    localparam int REM_W   = SUM_W + QB;
    localparam int THR_W   = WORD_BITS - 1;

    localparam int NUM_MINORS = 9;
    localparam int NUM_TERMS  = 12;
    localparam int NUM_COEF   = 6;

    localparam int APB_DW  = 32;
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-3:0] REG_DET_THRESHOLD = '0;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic [3:0] t_midx;
    typedef logic [2:0] t_cidx;

    typedef struct packed {
        t_word nx;
        t_word ny;
        t_word nz;
        t_word dterm;
    } t_plane;

    typedef struct packed {
        t_plane p1;
        t_plane p2;
        t_plane p3;
    } t_planes;

    typedef struct packed {
        logic signed [SUM_W-1:0] det;
        logic signed [SUM_W-1:0] num_x;
        logic signed [SUM_W-1:0] num_y;
        logic signed [SUM_W-1:0] num_z;
    } t_sums;

    typedef struct packed {
        t_word x;
        t_word y;
        t_word z;
        logic  solved;
    } t_result;

    // 2x2 minors a*b - c*e, operands as row*3+col into the normal matrix
    localparam t_midx MINOR_SRC [NUM_MINORS][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd3, 4'd8, 4'd5, 4'd6},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd8, 4'd2, 4'd7},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd0, 4'd5, 4'd2, 4'd3},
        '{4'd0, 4'd7, 4'd1, 4'd6},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // expansion terms: det, x, y, z numerators, three terms each
    // coefficients: first-row normal then the three distance terms
    localparam t_cidx EXP_COEF [NUM_TERMS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5, 3'd3, 3'd4, 3'd5
    };
    localparam t_midx EXP_MINOR [NUM_TERMS] = '{
        4'd0, 4'd1, 4'd2, 4'd0, 4'd3, 4'd4, 4'd1, 4'd5, 4'd6, 4'd2, 4'd7, 4'd8
    };
    // right-hand side is -d, so the x and z rows start negative
    localparam logic EXP_NEG [NUM_TERMS] = '{
        1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1
    };

endpackage

`default_nettype wire

// ===== rtl/tpi_in_if.sv =====
// request channel carrying three planes
// depends on tpi_pkg
`default_nettype none

interface tpi_in_if import tpi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word p1_nx;
    t_word p1_ny;
    t_word p1_nz;
    t_word p1_dist;
    t_word p2_nx;
    t_word p2_ny;
    t_word p2_nz;
    t_word p2_dist;
    t_word p3_nx;
    t_word p3_ny;
    t_word p3_nz;
    t_word p3_dist;

    modport source (
        output valid, p1_nx, p1_ny, p1_nz, p1_dist, p2_nx, p2_ny, p2_nz, p2_dist,
               p3_nx, p3_ny, p3_nz, p3_dist,
        input  ready
    );
    modport sink (
        input  valid, p1_nx, p1_ny, p1_nz, p1_dist, p2_nx, p2_ny, p2_nz, p2_dist,
               p3_nx, p3_ny, p3_nz, p3_dist,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/tpi_out_if.sv =====
// result channel carrying the intersection point
// depends on tpi_pkg
`default_nettype none

interface tpi_out_if import tpi_pkg::*; ();
    logic  valid;
    logic  ready;
    t_word point_x;
    t_word point_y;
    t_word point_z;
    logic  solved;

    modport source (
        output valid, point_x, point_y, point_z, solved,
        input  ready
    );
    modport sink (
        input  valid, point_x, point_y, point_z, solved,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/three_plane_intersect.sv =====
// Three-plane intersection by Cramer's rule on signed fixed-point planes. One
// request enters per clock when the output side does not stall: five stages
// form the minors, split products and cofactor sums, then a divider pipeline
// takes magnitudes, tests for a degenerate determinant, resolves one quotient
// bit per stage over 31 stages and applies sign and saturation in the output
// register. Bubbles close up under back-pressure. det_threshold sits at byte
// address 0 of the APB port.
// depends on tpi_pkg, tpi_in_if, tpi_out_if, tpi_front, tpi_div
`default_nettype none

module three_plane_intersect import tpi_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tpi_in_if.sink                  i_in,
    tpi_out_if.source               o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]       prdata,
    output logic                    pready
);

    logic [THR_W-1:0] r_det_threshold;
    t_planes          planes;
    t_sums            sums;
    t_result          result;
    logic             f_valid;
    logic             f_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_threshold <= THR_W'(1);
        end else if (psel && penable && pwrite
                     && (paddr[PADDR_W-1:2] == REG_DET_THRESHOLD)) begin
            r_det_threshold <= pwdata[THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_DET_THRESHOLD) prdata = APB_DW'(r_det_threshold);
    end

    always_comb begin
        planes.p1.nx    = i_in.p1_nx;
        planes.p1.ny    = i_in.p1_ny;
        planes.p1.nz    = i_in.p1_nz;
        planes.p1.dterm = i_in.p1_dist;
        planes.p2.nx    = i_in.p2_nx;
        planes.p2.ny    = i_in.p2_ny;
        planes.p2.nz    = i_in.p2_nz;
        planes.p2.dterm = i_in.p2_dist;
        planes.p3.nx    = i_in.p3_nx;
        planes.p3.ny    = i_in.p3_ny;
        planes.p3.nz    = i_in.p3_nz;
        planes.p3.dterm = i_in.p3_dist;
    end

    tpi_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_planes (planes),
        .o_valid  (f_valid),
        .i_ready  (f_ready),
        .o_sums   (sums)
    );

    tpi_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (f_valid),
        .o_ready  (f_ready),
        .i_sums   (sums),
        .i_thr    (r_det_threshold),
        .o_valid  (o_out.valid),
        .i_ready  (o_out.ready),
        .o_result (result)
    );

    assign o_out.point_x = result.x;
    assign o_out.point_y = result.y;
    assign o_out.point_z = result.z;
    assign o_out.solved  = result.solved;

endmodule

`default_nettype wire

// ===== rtl/tpi_front.sv =====
// determinant front end: 2x2 minors, split partial products and cofactor sums
// depends on tpi_pkg; five elastic register stages
`default_nettype none

module tpi_front import tpi_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire t_planes i_planes,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_sums        o_sums
);

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   mv;

    t_word nm [9];
    t_word cf [NUM_COEF];

    logic signed [PROD_W-1:0]  r1_prod  [2*NUM_MINORS];
    t_word                     r1_coef  [NUM_COEF];
    logic signed [MINOR_W-1:0] r2_minor [NUM_MINORS];
    t_word                     r2_coef  [NUM_COEF];
    logic signed [PP_W-1:0]    r3_lo    [NUM_TERMS];
    logic signed [PP_W-1:0]    r3_hi    [NUM_TERMS];
    logic signed [SUM_W-1:0]   n4_term  [NUM_TERMS];
    logic signed [SUM_W-1:0]   r4_term  [NUM_TERMS];
    logic signed [SUM_W-1:0]   r5_sum   [4];

    // a stage takes a new item when empty or when its item moves on
    always_comb begin
        mv[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            mv[k] = ~r_v[k] | mv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (mv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (mv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        nm[0] = i_planes.p1.nx;
        nm[1] = i_planes.p1.ny;
        nm[2] = i_planes.p1.nz;
        nm[3] = i_planes.p2.nx;
        nm[4] = i_planes.p2.ny;
        nm[5] = i_planes.p2.nz;
        nm[6] = i_planes.p3.nx;
        nm[7] = i_planes.p3.ny;
        nm[8] = i_planes.p3.nz;
        cf[0] = i_planes.p1.nx;
        cf[1] = i_planes.p1.ny;
        cf[2] = i_planes.p1.nz;
        cf[3] = i_planes.p1.dterm;
        cf[4] = i_planes.p2.dterm;
        cf[5] = i_planes.p3.dterm;
    end

    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            for (int k = 0; k < NUM_MINORS; k++) begin
                r1_prod[2*k]   <= nm[MINOR_SRC[k][0]] * nm[MINOR_SRC[k][1]];
                r1_prod[2*k+1] <= nm[MINOR_SRC[k][2]] * nm[MINOR_SRC[k][3]];
            end
            r1_coef <= cf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[1]) begin
            for (int k = 0; k < NUM_MINORS; k++) begin
                r2_minor[k] <= MINOR_W'(r1_prod[2*k]) - MINOR_W'(r1_prod[2*k+1]);
            end
            r2_coef <= r1_coef;
        end
    end

    // minor split into an unsigned low word and a signed high part
    always_ff @(posedge i_clk) begin
        if (mv[2]) begin
            for (int t = 0; t < NUM_TERMS; t++) begin
                r3_lo[t] <= r2_coef[EXP_COEF[t]]
                          * $signed({1'b0, r2_minor[EXP_MINOR[t]][WORD_BITS-1:0]});
                r3_hi[t] <= r2_coef[EXP_COEF[t]]
                          * $signed(r2_minor[EXP_MINOR[t]][MINOR_W-1:WORD_BITS]);
            end
        end
    end

    always_comb begin
        logic signed [SUM_W-1:0] full;
        for (int t = 0; t < NUM_TERMS; t++) begin
            full = (SUM_W'(r3_hi[t]) <<< WORD_BITS) + SUM_W'(r3_lo[t]);
            n4_term[t] = EXP_NEG[t] ? -full : full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[3]) r4_term <= n4_term;
    end

    always_ff @(posedge i_clk) begin
        if (mv[4]) begin
            for (int e = 0; e < 4; e++) begin
                r5_sum[e] <= r4_term[3*e] + r4_term[3*e+1] + r4_term[3*e+2];
            end
        end
    end

    assign o_sums.det   = r5_sum[0];
    assign o_sums.num_x = r5_sum[1];
    assign o_sums.num_y = r5_sum[2];
    assign o_sums.num_z = r5_sum[3];
    assign o_valid      = r_v[NSTG-1];
    assign o_ready      = mv[0];

endmodule

`default_nettype wire

// ===== rtl/tpi_div.sv =====
// quotient pipeline: magnitudes, degenerate test, one quotient bit per stage,
// sign and saturation; three lanes share one valid chain. depends on tpi_pkg
`default_nettype none

module tpi_div import tpi_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire t_sums            i_sums,
    input  wire logic [THR_W-1:0] i_thr,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output t_result               o_result
);

    localparam int NSTG = QB + 3;
    localparam int OST  = NSTG - 1;
    localparam logic [WORD_BITS-1:0] SAT_POS = {1'b0, {QB{1'b1}}};
    localparam logic [WORD_BITS-1:0] SAT_NEG = {1'b1, {QB{1'b0}}};

    logic [NSTG-1:0] r_v;
    logic [NSTG:0]   mv;

    logic signed [SUM_W-1:0] nums [3];
    logic [SUM_W-1:0] n0_dmag;
    logic [SUM_W-1:0] n0_nmag [3];

    logic [SUM_W-1:0] r0_dmag;
    logic [SUM_W-1:0] r0_nmag [3];
    logic             r0_neg  [3];

    logic [SUM_W-1:0] r1_dmag;
    logic [REM_W-1:0] r1_rem  [3];
    logic             r1_neg  [3];
    logic             r1_sat  [3];
    logic             r1_degen;

    logic [REM_W-1:0] r_brem   [QB][3];
    logic [QB-1:0]    r_bq     [QB][3];
    logic [SUM_W-1:0] r_bdmag  [QB];
    logic             r_bneg   [QB][3];
    logic             r_bsat   [QB][3];
    logic             r_bdegen [QB];

    t_word   n_pt [3];
    t_result r_out;

    always_comb begin
        mv[NSTG] = i_ready;
        for (int k = NSTG - 1; k >= 0; k--) begin
            mv[k] = ~r_v[k] | mv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (mv[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NSTG; k++) begin
                if (mv[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    always_comb begin
        nums[0] = i_sums.num_x;
        nums[1] = i_sums.num_y;
        nums[2] = i_sums.num_z;
        n0_dmag = i_sums.det[SUM_W-1] ? SUM_W'(-i_sums.det) : SUM_W'(i_sums.det);
        for (int l = 0; l < 3; l++) begin
            n0_nmag[l] = nums[l][SUM_W-1] ? SUM_W'(-nums[l]) : SUM_W'(nums[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[0]) begin
            r0_dmag <= n0_dmag;
            r0_nmag <= n0_nmag;
            for (int l = 0; l < 3; l++) begin
                r0_neg[l] <= nums[l][SUM_W-1] ^ i_sums.det[SUM_W-1];
            end
        end
    end

    // quotient of 2^(WORD_BITS-1) or more saturates; threshold is in Q format
    always_ff @(posedge i_clk) begin
        if (mv[1]) begin
            r1_dmag  <= r0_dmag;
            r1_neg   <= r0_neg;
            r1_degen <= (r0_dmag == '0)
                      || (r0_dmag < (SUM_W'(i_thr) << (2 * FRAC_BITS)));
            for (int l = 0; l < 3; l++) begin
                r1_rem[l] <= REM_W'(r0_nmag[l]);
                r1_sat[l] <= REM_W'(r0_nmag[l]) >= (REM_W'(r0_dmag) << QB);
            end
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_bit
        localparam int BIT = QB - 1 - k;

        logic [REM_W-1:0] s_rem [3];
        logic [QB-1:0]    s_q   [3];
        logic [SUM_W-1:0] s_dmag;
        logic             s_neg [3];
        logic             s_sat [3];
        logic             s_degen;
        logic [REM_W-1:0] s_div;
        logic             s_ge  [3];

        if (k == 0) begin : g_first
            always_comb begin
                s_rem   = r1_rem;
                s_dmag  = r1_dmag;
                s_neg   = r1_neg;
                s_sat   = r1_sat;
                s_degen = r1_degen;
                for (int l = 0; l < 3; l++) s_q[l] = '0;
            end
        end else begin : g_next
            always_comb begin
                s_rem   = r_brem[k-1];
                s_q     = r_bq[k-1];
                s_dmag  = r_bdmag[k-1];
                s_neg   = r_bneg[k-1];
                s_sat   = r_bsat[k-1];
                s_degen = r_bdegen[k-1];
            end
        end

        always_comb begin
            s_div = REM_W'(s_dmag) << BIT;
            for (int l = 0; l < 3; l++) s_ge[l] = s_rem[l] >= s_div;
        end

        always_ff @(posedge i_clk) begin
            if (mv[2+k]) begin
                r_bdmag[k]  <= s_dmag;
                r_bneg[k]   <= s_neg;
                r_bsat[k]   <= s_sat;
                r_bdegen[k] <= s_degen;
                for (int l = 0; l < 3; l++) begin
                    r_brem[k][l] <= s_ge[l] ? s_rem[l] - s_div : s_rem[l];
                    r_bq[k][l]   <= s_q[l] | (QB'(s_ge[l]) << BIT);
                end
            end
        end
    end

    always_comb begin
        logic [WORD_BITS-1:0] mag;
        for (int l = 0; l < 3; l++) begin
            mag = {1'b0, r_bq[QB-1][l]};
            if (r_bdegen[QB-1]) begin
                n_pt[l] = '0;
            end else if (r_bsat[QB-1][l]) begin
                n_pt[l] = r_bneg[QB-1][l] ? SAT_NEG : SAT_POS;
            end else begin
                n_pt[l] = r_bneg[QB-1][l] ? -mag : mag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv[OST]) begin
            r_out.x      <= n_pt[0];
            r_out.y      <= n_pt[1];
            r_out.z      <= n_pt[2];
            r_out.solved <= ~r_bdegen[QB-1];
        end
    end

    assign o_result = r_out;
    assign o_valid  = r_v[OST];
    assign o_ready  = mv[0];

    // after the last bit step the remainder is below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[OST-1] && !r_bdegen[QB-1] |->
            (r_bsat[QB-1][0] || (r_brem[QB-1][0] < REM_W'(r_bdmag[QB-1])))
         && (r_bsat[QB-1][1] || (r_brem[QB-1][1] < REM_W'(r_bdmag[QB-1])))
         && (r_bsat[QB-1][2] || (r_brem[QB-1][2] < REM_W'(r_bdmag[QB-1]))))
        else $error("quotient remainder out of bound");

    // a zero divisor must have been flagged degenerate
    a_nonzero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[OST-1] && !r_bdegen[QB-1] |-> r_bdmag[QB-1] != '0)
        else $error("zero determinant reached the divider unflagged");

    // back-pressure only when every stage holds an item
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (&r_v) && !i_ready)
        else $error("pipeline stalled with an empty stage");

endmodule

`default_nettype wire

// ===== tb/tb_three_plane_intersect.sv =====
// self-checking testbench for three_plane_intersect: directed plane triples, then
// random ones over several det_threshold settings, with random stalls on both sides
// depends on tpi_pkg, tpi_in_if, tpi_out_if and the three_plane_intersect rtl
`timescale 1ns / 1ps

module tb_three_plane_intersect;
    import tpi_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int ITEMS_PER_SET  = 180;
    localparam int NUM_SETS       = 5;
    localparam logic [PADDR_W-1:0] ADDR_DET_THRESHOLD = {REG_DET_THRESHOLD, 2'b00};
    localparam t_word W_MIN = 32'sh8000_0000;
    localparam t_word W_MAX = 32'sh7fff_ffff;
    localparam t_word W_ONE = 32'sh0001_0000;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        t_planes p;
        bit      typed;
        t_result want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [APB_DW-1:0]  pwdata;
    logic [APB_DW-1:0]  prdata;
    logic               pready;

    tpi_in_if  in_if ();
    tpi_out_if out_if ();

    three_plane_intersect DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_result     point_q[$];
    logic [30:0] cur_thr;
    int          mismatches;
    int          idle_cycles;
    bit          quiet;
    bit          hold_req;
    t_row        rows[$];

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // truncating quotient of the exact sums, saturated to the word range
    function automatic t_word q16_quotient(t_wide num, t_wide den);
        logic [127:0] a;
        logic [127:0] b;
        logic [127:0] q;
        bit neg;
        neg = num[127] ^ den[127];
        a = num[127] ? -num : num;
        b = den[127] ? -den : den;
        q = a / b;
        if (q >= 128'h8000_0000)
            return neg ? W_MIN : W_MAX;
        return neg ? t_word'(-q[31:0]) : t_word'(q[31:0]);
    endfunction

    function automatic t_result solve_planes(t_planes p, logic [30:0] thr);
        t_wide m00, m01, m02, m10, m11, m12, m20, m21, m22, d0, d1, d2;
        t_wide ca, cb, cc, ce, cf, cg, ch, ci, cj, det, adet, lim, nx, ny, nz;
        t_result r;
        m00 = p.p1.nx; m01 = p.p1.ny; m02 = p.p1.nz; d0 = p.p1.dterm;
        m10 = p.p2.nx; m11 = p.p2.ny; m12 = p.p2.nz; d1 = p.p2.dterm;
        m20 = p.p3.nx; m21 = p.p3.ny; m22 = p.p3.nz; d2 = p.p3.dterm;
        ca = m11 * m22 - m12 * m21;
        cb = m10 * m22 - m12 * m20;
        cc = m10 * m21 - m11 * m20;
        det = m00 * ca - m01 * cb + m02 * cc;
        adet = det[127] ? -det : det;
        lim = t_wide'({97'b0, thr}) <<< (2 * FRAC_BITS);
        r = '0;
        if (det == 0 || adet < lim)
            return r;
        ce = m01 * m22 - m02 * m21;
        cf = m01 * m12 - m02 * m11;
        cg = m00 * m22 - m02 * m20;
        ch = m00 * m12 - m02 * m10;
        ci = m00 * m21 - m01 * m20;
        cj = m00 * m11 - m01 * m10;
        // right-hand side is -d
        nx = -(d0 * ca - d1 * ce + d2 * cf);
        ny = d0 * cb - d1 * cg + d2 * ch;
        nz = -(d0 * cc - d1 * ci + d2 * cj);
        r.x = q16_quotient(nx, det);
        r.y = q16_quotient(ny, det);
        r.z = q16_quotient(nz, det);
        r.solved = 1'b1;
        return r;
    endfunction

    function automatic t_plane mk_plane(t_word nx, t_word ny, t_word nz, t_word d);
        t_plane pl;
        pl.nx = nx; pl.ny = ny; pl.nz = nz; pl.dterm = d;
        return pl;
    endfunction

    function automatic void add_row(t_plane a, t_plane b, t_plane c, bit degen);
        t_row r;
        r.p.p1 = a; r.p.p2 = b; r.p.p3 = c;
        r.typed = degen;
        r.want = '0;
        rows.push_back(r);
    endfunction

    function automatic t_word rand_word(int mode);
        case (mode)
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            default: begin
                case ($urandom_range(0, 5))
                    0: return W_MIN;
                    1: return W_MAX;
                    2: return '0;
                    3: return 32'sh1;
                    4: return -32'sh1;
                    default: return W_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic t_planes rand_planes();
        t_planes p;
        int mode;
        mode = $urandom_range(0, 2);
        p.p1 = mk_plane(rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode));
        p.p2 = mk_plane(rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode));
        p.p3 = mk_plane(rand_word(mode), rand_word(mode), rand_word(mode), rand_word(mode));
        // some parallel or coincident normals
        if ($urandom_range(0, 9) == 0) begin
            p.p3.nx = p.p1.nx; p.p3.ny = p.p1.ny; p.p3.nz = p.p1.nz;
        end
        return p;
    endfunction

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_threshold(logic [30:0] thr);
        apb_write(ADDR_DET_THRESHOLD, {1'b0, thr});
        cur_thr = thr;
    endtask

    task automatic wait_drained();
        while (point_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_planes(t_planes p, bit typed, t_result want);
        in_if.valid   <= 1'b1;
        in_if.p1_nx   <= p.p1.nx;
        in_if.p1_ny   <= p.p1.ny;
        in_if.p1_nz   <= p.p1.nz;
        in_if.p1_dist <= p.p1.dterm;
        in_if.p2_nx   <= p.p2.nx;
        in_if.p2_ny   <= p.p2.ny;
        in_if.p2_nz   <= p.p2.nz;
        in_if.p2_dist <= p.p2.dterm;
        in_if.p3_nx   <= p.p3.nx;
        in_if.p3_ny   <= p.p3.ny;
        in_if.p3_nz   <= p.p3.nz;
        in_if.p3_dist <= p.p3.dterm;
        do @(posedge i_clk); while (!in_if.ready);
        point_q.push_back(typed ? want : solve_planes(p, cur_thr));
    endtask

    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic run_rows();
        foreach (rows[i]) begin
            send_planes(rows[i].p, rows[i].typed, rows[i].want);
            sender_gap();
        end
        in_if.valid <= 1'b0;
    endtask

    // result checking
    always @(posedge i_clk) begin
        t_result exp_r;
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.x = out_if.point_x;
            got.y = out_if.point_y;
            got.z = out_if.point_z;
            got.solved = out_if.solved;
            if (point_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result x=%h y=%h z=%h solved=%b",
                             got.x, got.y, got.z, got.solved);
            end else begin
                exp_r = point_q.pop_front();
                if (got.x !== exp_r.x || got.y !== exp_r.y || got.z !== exp_r.z ||
                    got.solved !== exp_r.solved) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected x=%h y=%h z=%h solved=%b, ",
                                  "got x=%h y=%h z=%h solved=%b"},
                                 exp_r.x, exp_r.y, exp_r.z, exp_r.solved,
                                 got.x, got.y, got.z, got.solved);
                end
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [30:0] thr_set [NUM_SETS];
        t_result none;
        none = '0;
        mismatches = 0;
        idle_cycles = 0;
        quiet = 1'b0;
        hold_req = 1'b0;
        cur_thr = 31'd1;
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_if.valid = 1'b0;
        in_if.p1_nx = '0; in_if.p1_ny = '0; in_if.p1_nz = '0; in_if.p1_dist = '0;
        in_if.p2_nx = '0; in_if.p2_ny = '0; in_if.p2_nz = '0; in_if.p2_dist = '0;
        in_if.p3_nx = '0; in_if.p3_ny = '0; in_if.p3_nz = '0; in_if.p3_dist = '0;

        // zero, all-equal and parallel normals are degenerate whatever the threshold
        add_row(mk_plane(0, 0, 0, 0), mk_plane(0, 0, 0, 0), mk_plane(0, 0, 0, 0), 1);
        add_row(mk_plane(W_MIN, W_MIN, W_MIN, W_MIN), mk_plane(W_MIN, W_MIN, W_MIN, W_MIN),
                mk_plane(W_MIN, W_MIN, W_MIN, W_MIN), 1);
        add_row(mk_plane(W_MAX, W_MAX, W_MAX, W_MAX), mk_plane(W_MAX, W_MAX, W_MAX, W_MAX),
                mk_plane(W_MAX, W_MAX, W_MAX, W_MAX), 1);
        add_row(mk_plane(W_ONE, 2 * W_ONE, 3 * W_ONE, W_ONE),
                mk_plane(2 * W_ONE, 4 * W_ONE, 6 * W_ONE, -W_ONE),
                mk_plane(0, W_ONE, 0, 0), 1);
        add_row(mk_plane(W_ONE, 0, 0, W_ONE), mk_plane(0, W_ONE, 0, 2 * W_ONE),
                mk_plane(0, 0, W_ONE, 3 * W_ONE), 0);
        add_row(mk_plane(W_ONE, 0, 0, W_MIN), mk_plane(0, W_ONE, 0, W_MAX),
                mk_plane(0, 0, W_ONE, 0), 0);
        // unit-lsb normals (tiny determinant, huge quotients), then full-scale diagonal normals
        add_row(mk_plane(1, 0, 0, W_MIN), mk_plane(0, 1, 0, W_MAX),
                mk_plane(0, 0, 1, 1), 0);
        add_row(mk_plane(-1, 0, 0, W_MAX), mk_plane(0, 1, 0, W_MIN),
                mk_plane(0, 0, 1, -1), 0);
        add_row(mk_plane(W_MAX, 0, 0, W_MIN), mk_plane(0, W_MIN, 0, W_MAX),
                mk_plane(0, 0, W_MAX, W_MIN), 0);
        // swapped rows give a negative determinant
        add_row(mk_plane(0, W_ONE, 0, W_ONE), mk_plane(W_ONE, 0, 0, -W_ONE),
                mk_plane(0, 0, W_ONE, W_ONE), 0);
        // determinant right at and just under the threshold of one
        add_row(mk_plane(W_ONE, 0, 0, W_ONE), mk_plane(0, W_ONE, 0, W_ONE),
                mk_plane(0, 0, 1, 1), 0);
        add_row(mk_plane(W_ONE, 0, 0, W_ONE), mk_plane(0, 32'sh0000_ffff, 0, W_ONE),
                mk_plane(0, 0, 1, 1), 0);
        add_row(mk_plane(W_MIN, W_MAX, 3, -7), mk_plane(5, W_MIN, W_MAX, W_MAX),
                mk_plane(W_MAX, 11, W_MIN, W_MIN), 0);
        add_row(mk_plane(32'sh0003_8000, -32'sh0001_4000, 32'sh0000_c000, 32'sh0012_3456),
                mk_plane(-32'sh0002_0000, 32'sh0005_0000, 32'sh0001_0000, -32'sh0007_8000),
                mk_plane(32'sh0001_0000, 32'sh0002_0000, -32'sh0004_0000, 32'sh0000_0001), 0);

        thr_set[0] = 31'd1;
        thr_set[1] = 31'd0;
        thr_set[2] = 31'h7fff_ffff;
        thr_set[3] = 31'($urandom_range(1, 32'h0000_ffff));
        thr_set[4] = 31'($urandom);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset threshold first, then the same rows at zero threshold
        run_rows();
        wait_drained();
        set_threshold(31'd0);
        run_rows();
        wait_drained();

        for (int s = 0; s < NUM_SETS; s++) begin
            set_threshold(thr_set[s]);
            quiet = (s == NUM_SETS - 1);
            for (int n = 0; n < ITEMS_PER_SET; n++) begin
                if (s == 1 && n == 20)
                    hold_req = 1'b1;
                if (s == 2 && n == 100) begin
                    in_if.valid <= 1'b0;
                    while (point_q.size() > 0) @(posedge i_clk);
                end
                send_planes(rand_planes(), 1'b0, none);
                sender_gap();
            end
            in_if.valid <= 1'b0;
            wait_drained();
        end

        if (mismatches == 0 && point_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/tpi_pkg.sv
rtl/tpi_in_if.sv
rtl/tpi_out_if.sv
rtl/tpi_front.sv
rtl/tpi_div.sv
rtl/three_plane_intersect.sv
tb/tb_three_plane_intersect.sv
